/* sv/gfau_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the GF(2^n) arithmetic unit.
// No dependencies; imported by the cell and the top level.
package gfau_pkg;

  localparam int FIELD_BITS_DEF = 8;
  localparam int POLY_RESET     = 283;  // x^8 + x^4 + x^3 + x + 1

  localparam int ACT_W = 2;
  localparam logic [ACT_W-1:0] ACT_ADD = 2'd0;
  localparam logic [ACT_W-1:0] ACT_MUL = 2'd1;
  localparam logic [ACT_W-1:0] ACT_INV = 2'd2;

  // cell roles in the square-and-multiply chain
  localparam logic ROLE_SQ   = 1'b0;
  localparam logic ROLE_MULA = 1'b1;

  typedef struct packed {
    logic             vld;
    logic [ACT_W-1:0] act;
  } ctl_t;

endpackage

/* sv/gfau_cell.sv */
`timescale 1ns / 1ps
// One cell of the multiply chain: a single GF(2^n) multiply and a stage register.
// Depends on gfau_pkg.
module gfau_cell #(
  parameter int   FIELD_BITS = gfau_pkg::FIELD_BITS_DEF,
  parameter logic ROLE       = gfau_pkg::ROLE_SQ,
  parameter logic FIRST      = 1'b0
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  en,
  input  logic [FIELD_BITS-1:0] poly_low,
  input  gfau_pkg::ctl_t        ctl_i,
  input  logic [FIELD_BITS-1:0] a_i,
  input  logic [FIELD_BITS-1:0] acc_i,
  output gfau_pkg::ctl_t        ctl_o,
  output logic [FIELD_BITS-1:0] a_o,
  output logic [FIELD_BITS-1:0] acc_o
);
  import gfau_pkg::*;

  localparam int N  = FIELD_BITS;
  localparam int PW = 2 * N - 1;

  function automatic logic [N-1:0] gmul(input logic [N-1:0] x, input logic [N-1:0] y,
                                        input logic [N-1:0] low);
    logic [PW-1:0] p;
    p = '0;
    for (int i = 0; i < N; i++) begin
      if (y[i]) p = p ^ (PW'(x) << i);
    end
    // fold top coefficients down, x^n == low
    for (int i = PW - 1; i >= N; i--) begin
      if (p[i]) begin
        p[i] = 1'b0;
        p = p ^ (PW'(low) << (i - N));
      end
    end
    return p[N-1:0];
  endfunction

  ctl_t        ctl_r;
  logic [N-1:0] a_r, acc_r, acc_nxt;
  logic [N-1:0] mx, my;
  logic         do_mul;

  always_comb begin
    do_mul = 1'b0;
    mx     = acc_i;
    my     = acc_i;
    case (ctl_i.act)
      ACT_INV: begin
        do_mul = 1'b1;
        my     = (ROLE == ROLE_SQ) ? acc_i : a_i;
      end
      ACT_MUL: begin
        do_mul = FIRST;
        mx     = a_i;
      end
      default: do_mul = 1'b0;
    endcase
    acc_nxt = do_mul ? gmul(mx, my, poly_low) : acc_i;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else if (en) begin
      ctl_r <= ctl_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_r   <= a_i;
      acc_r <= acc_nxt;
    end
  end

  assign ctl_o = ctl_r;
  assign a_o   = a_r;
  assign acc_o = acc_r;

endmodule

/* sv/gf256_arith_unit_top.sv */
`timescale 1ns / 1ps
// Top level of the GF(2^n) arithmetic unit: input stage, chain of multiply cells.
// Depends on gfau_pkg and gfau_cell.

// Add, multiply and inverse in GF(2^FIELD_BITS) with a writable reduction
// polynomial (reset 0x11B; its top bit is always taken as set). One word is taken
// every clock cycle while the output is not stalled. Every word runs through a
// chain of 2*FIELD_BITS-1 cells (15 for GF(2^8)); inverse multiplies in each,
// multiply only in the first, add in none. Add and multiply ride the same chain
// to keep order. The last cell's register is the output register; a stall on the
// output holds the whole chain. Inverse of zero returns zero, action code 3
// returns zero. Write the polynomial only while the chain is empty.
module gf256_arith_unit_top #(
  parameter int FIELD_BITS = gfau_pkg::FIELD_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  // cfg_data: reduction_poly
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [FIELD_BITS:0]                   cfg_data,
  // in_tdata: operand_a, operand_b, zero fill
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  input  logic [((2*FIELD_BITS+7)/8)*8-1:0]     in_tdata,
  // in_tuser: action
  input  logic [gfau_pkg::ACT_W-1:0]            in_tuser,
  // out_tdata: result, zero fill
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  output logic [((FIELD_BITS+7)/8)*8-1:0]       out_tdata
);
  import gfau_pkg::*;

  localparam int N      = FIELD_BITS;
  localparam int STAGES = 2 * N - 1;
  localparam int OUT_DW = ((N + 7) / 8) * 8;
  localparam int OCC_W  = $clog2(STAGES + 1);

  logic [N-1:0] poly_r;
  logic         adv;

  ctl_t         ctl [0:STAGES];
  logic [N-1:0] a_s [0:STAGES];
  logic [N-1:0] acc [0:STAGES];
  logic [STAGES-1:0] vld_vec;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      poly_r <= N'(POLY_RESET);
    end else if (cfg_valid && cfg_ready) begin
      poly_r <= cfg_data[N-1:0];
    end
  end

  assign adv       = !ctl[STAGES].vld || out_tready;
  assign in_tready = adv;

  // entry: add finishes here, multiply seeds with b, inverse seeds with one
  always_comb begin
    ctl[0].vld = in_tvalid;
    ctl[0].act = in_tuser;
    a_s[0]     = in_tdata[N-1:0];
    case (in_tuser)
      ACT_ADD: acc[0] = in_tdata[N-1:0] ^ in_tdata[2*N-1:N];
      ACT_MUL: acc[0] = in_tdata[2*N-1:N];
      ACT_INV: acc[0] = N'(1);
      default: acc[0] = '0;
    endcase
  end

  for (genvar k = 0; k < STAGES; k++) begin : g_cell
    gfau_cell #(
      .FIELD_BITS (N),
      .ROLE       ((k % 2 == 0) ? ROLE_SQ : ROLE_MULA),
      .FIRST      (k == 0)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .en       (adv),
      .poly_low (poly_r),
      .ctl_i    (ctl[k]),
      .a_i      (a_s[k]),
      .acc_i    (acc[k]),
      .ctl_o    (ctl[k+1]),
      .a_o      (a_s[k+1]),
      .acc_o    (acc[k+1])
    );
    assign vld_vec[k] = ctl[k+1].vld;
  end

  assign out_tvalid = ctl[STAGES].vld;
  assign out_tdata  = OUT_DW'(acc[STAGES]);

  // words in flight, for checking only
  logic [OCC_W-1:0] occ_r, occ_nxt;

  always_comb begin
    occ_nxt = occ_r;
    if (in_tvalid && in_tready) occ_nxt = occ_nxt + OCC_W'(1);
    if (out_tvalid && out_tready) occ_nxt = occ_nxt - OCC_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r <= '0;
    end else begin
      occ_r <= occ_nxt;
    end
  end

  a_occ_match: assert property (@(posedge clk) disable iff (!rst_n)
    32'(occ_r) == $countones(vld_vec))
    else $error("words in flight do not match chain valid bits");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid right after reset");

  a_entry: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> ctl[1].vld)
    else $error("accepted word missing from first cell");

endmodule
